// ----- rtl/tmrdiv_pkg.sv -----
// Shared types, register indexes and prescale periods for the timer/divider block.
package tmrdiv_pkg;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;
    localparam int unsigned CountW   = 11;  // holds 1..1024 between steps

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TIMER_ENABLE = 2'd0,
        CFG_CLOCK_SELECT = 2'd1,
        CFG_RELOAD_VALUE = 2'd2
    } cfg_index_t;

    localparam logic [1:0] SEL_1024 = 2'd0;
    localparam logic [1:0] SEL_16   = 2'd1;
    localparam logic [1:0] SEL_64   = 2'd2;
    localparam logic [1:0] SEL_256  = 2'd3;

    localparam logic [CountW-1:0] PERIOD_RESET = 11'd1024;

    typedef struct packed {
        logic       timer_enable;
        logic [1:0] clock_select;
        logic [7:0] reload_value;
    } cfg_t;

    function automatic logic [CountW-1:0] period_of(input logic [1:0] sel);
        logic [CountW-1:0] p;
        case (sel)
            SEL_16:  p = 11'd16;
            SEL_64:  p = 11'd64;
            SEL_256: p = 11'd256;
            default: p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/tmrdiv_cfg.sv -----
// Configuration register file: enable, clock select and reload value.
module tmrdiv_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tmrdiv_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tmrdiv_pkg::CfgDataW-1:0]  cfg_wdata,
    output tmrdiv_pkg::cfg_t                 cfg
);

    tmrdiv_pkg::cfg_t cfg_reg;
    tmrdiv_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                tmrdiv_pkg::CFG_TIMER_ENABLE: cfg_next.timer_enable = cfg_wdata[0];
                tmrdiv_pkg::CFG_CLOCK_SELECT: cfg_next.clock_select = cfg_wdata[1:0];
                tmrdiv_pkg::CFG_RELOAD_VALUE: cfg_next.reload_value = cfg_wdata;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/tmrdiv_core.sv -----
// Timer state update: divider, prescale countdown, counter and result register.
module tmrdiv_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       cycles,
    input  tmrdiv_pkg::cfg_t cfg,
    output logic [7:0]       divider_value,
    output logic [7:0]       counter_value,
    output logic             timer_irq
);

    logic [8:0]                     accum_reg, accum_next;
    logic [7:0]                     divider_reg, divider_next;
    logic [tmrdiv_pkg::CountW-1:0]  count_reg, count_next;
    logic [7:0]                     counter_reg, counter_next;
    logic [1:0]                     last_sel_reg, last_sel_next;
    logic                           irq_reg, irq_next;

    logic [8:0]                     accum_sum;
    logic [tmrdiv_pkg::CountW-1:0]  count_base;
    logic [tmrdiv_pkg::CountW:0]    count_diff;

    always_comb begin
        accum_sum = accum_reg + {1'b0, cycles};
        if (accum_sum[8]) begin
            // reached 256: drop remainder, tick divider
            accum_next   = '0;
            divider_next = divider_reg + 8'd1;
        end else begin
            accum_next   = accum_sum;
            divider_next = divider_reg;
        end

        // reload on a new select before counting down
        last_sel_next = cfg.clock_select;
        count_base    = (cfg.clock_select != last_sel_reg) ?
                        tmrdiv_pkg::period_of(cfg.clock_select) : count_reg;
        count_diff    = {1'b0, count_base} - {4'b0, cycles};

        count_next   = count_base;
        counter_next = counter_reg;
        irq_next     = 1'b0;
        if (cfg.timer_enable) begin
            count_next = count_diff[tmrdiv_pkg::CountW-1:0];
            if (count_diff[tmrdiv_pkg::CountW] || count_diff == '0) begin
                count_next = tmrdiv_pkg::period_of(cfg.clock_select);
                if (counter_reg == 8'hFF) begin
                    counter_next = cfg.reload_value;
                    irq_next     = 1'b1;
                end else begin
                    counter_next = counter_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg    <= '0;
            divider_reg  <= '0;
            count_reg    <= tmrdiv_pkg::PERIOD_RESET;
            counter_reg  <= '0;
            last_sel_reg <= tmrdiv_pkg::SEL_1024;
            irq_reg      <= 1'b0;
        end else if (step) begin
            accum_reg    <= accum_next;
            divider_reg  <= divider_next;
            count_reg    <= count_next;
            counter_reg  <= counter_next;
            last_sel_reg <= last_sel_next;
            irq_reg      <= irq_next;
        end
    end

    assign divider_value = divider_reg;
    assign counter_value = counter_reg;
    assign timer_irq     = irq_reg;

    a_accum_below_256: assert property (@(posedge aclk) disable iff (!aresetn)
        !accum_reg[8]) else $error("divider accumulator reached 256 between steps");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= tmrdiv_pkg::PERIOD_RESET)
        else $error("prescale countdown out of range");

    a_disabled_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !cfg.timer_enable |=> $stable(counter_reg) && !irq_reg)
        else $error("counter moved while timer disabled");

    a_irq_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        step && irq_next |=> counter_reg == $past(cfg.reload_value))
        else $error("overflow did not load reload value");

endmodule

// ----- rtl/timer_divider_with_reload_top.sv -----
// Programmable timer with free-running divider, prescaler and reload.
//
// Input channel (s_valid/s_ready, s_elapsed_cycles): one beat per emulated
// step, carrying the machine cycles elapsed since the previous beat.
// Result channel (m_valid/m_ready): one beat per input beat, in order,
// carrying the divider register, the timer counter and the interrupt pulse
// as they stand after that step.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write enable (0), clock
// select (1) and reload value (2); write only while idle.
// Path: a beat is captured in the input register and then, once the result
// slot is free or being drained, updated into the result register.
// Throughput: one beat per cycle while m_ready stays high, set by the
// combinational state update between the two registers.
// Stall: when m_ready is low the result holds, the input register fills,
// and s_ready drops only once both are occupied.
// Reset (aresetn low, synchronous): registers cleared except the input
// data register, prescale countdown set to 1024, both channels empty.
module timer_divider_with_reload_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [tmrdiv_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [tmrdiv_pkg::CfgDataW-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_elapsed_cycles,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_divider_value,
    output logic [7:0]                       m_counter_value,
    output logic                             m_timer_irq
);

    tmrdiv_pkg::cfg_t cfg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_cycles_reg;
    logic       out_valid_reg, out_valid_next;
    logic       step;

    // advance when the result slot is free or being drained
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_comb begin
        in_valid_next  = s_valid ? 1'b1 : (in_valid_reg && !step);
        out_valid_next = step ? 1'b1 : (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= s_ready ? in_valid_next : in_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cycles_reg <= s_elapsed_cycles;
        end
    end

    tmrdiv_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tmrdiv_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .cycles        (in_cycles_reg),
        .cfg           (cfg),
        .divider_value (m_divider_value),
        .counter_value (m_counter_value),
        .timer_irq     (m_timer_irq)
    );

    assign m_valid = out_valid_reg;

endmodule
